>>> hw/rtl/icos_pkg.sv
// ----------------------------------------------------------------------------
// icos_pkg
// Shared widths, types and codes of the icosphere triangle subdivider.
// ----------------------------------------------------------------------------
package icos_pkg;

  localparam int CoordW    = 16;
  localparam int MagW      = CoordW + 1;
  localparam int LenW      = 2 * MagW;
  localparam int FracShift = 28;
  localparam int RadW      = LenW + FracShift;
  localparam int SqrtSteps = RadW / 2;
  localparam int RootW     = SqrtSteps;
  localparam int SqRemW    = RootW + 3;
  localparam int QuotW     = 16;
  localparam int NumW      = MagW + FracShift + 1;
  localparam int DivRemW   = RootW + 1;
  localparam int NormLat   = 2 + SqrtSteps + 1 + QuotW + 1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [MagW-1:0] mag_t;
  typedef logic [QuotW-1:0] quot_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vec_t;

  typedef struct packed {
    vec_t c;
    vec_t b;
    vec_t a;
  } tri_t;

  typedef struct packed {
    mag_t [2:0] mag;
    logic [2:0] neg;
    logic       zero;
  } norm_side_t;

  typedef enum logic [1:0] {
    PieceEdgeB   = 2'd0,
    PieceCornerA = 2'd1,
    PieceCornerC = 2'd2,
    PieceCenter  = 2'd3
  } piece_e;

endpackage

>>> hw/rtl/icos_if.sv
// ----------------------------------------------------------------------------
// icos_if
// Valid/ready channels for input triangles and output sub-triangles.
// ----------------------------------------------------------------------------
interface icos_in_if;
  import icos_pkg::*;

  logic   valid;
  logic   ready;
  coord_t a_x;
  coord_t a_y;
  coord_t a_z;
  coord_t b_x;
  coord_t b_y;
  coord_t b_z;
  coord_t c_x;
  coord_t c_y;
  coord_t c_z;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    output ready
  );
endinterface

interface icos_out_if;
  import icos_pkg::*;

  logic       valid;
  logic       ready;
  coord_t     p_x;
  coord_t     p_y;
  coord_t     p_z;
  coord_t     q_x;
  coord_t     q_y;
  coord_t     q_z;
  coord_t     r_x;
  coord_t     r_y;
  coord_t     r_z;
  logic [1:0] piece;
  logic       last_piece;

  modport source (
    output valid, p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z, piece, last_piece,
    input  ready
  );
  modport sink (
    input  valid, p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z, piece, last_piece,
    output ready
  );
endinterface

>>> hw/rtl/icos_isqrt.sv
// ----------------------------------------------------------------------------
// icos_isqrt
// Pipelined integer square root of len * 2^28, one result bit per stage.
// ----------------------------------------------------------------------------
module icos_isqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [icos_pkg::LenW-1:0]  len_i,
  input  icos_pkg::norm_side_t       side_i,
  output logic [icos_pkg::RootW-1:0] root_o,
  output icos_pkg::norm_side_t       side_o
);
  import icos_pkg::*;

  logic [LenW-1:0]   len_q  [SqrtSteps];
  logic [SqRemW-1:0] rem_q  [SqrtSteps];
  logic [RootW-1:0]  root_q [SqrtSteps];
  norm_side_t        side_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    logic [SqRemW-1:0] rem_in;
    logic [SqRemW-1:0] shifted;
    logic [SqRemW-1:0] trial;
    logic [RootW-1:0]  root_in;
    logic [LenW-1:0]   len_in;
    logic [RadW-1:0]   rad;
    norm_side_t        side_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign len_in  = len_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign len_in  = len_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign rad     = {len_in, {FracShift{1'b0}}};
    assign shifted = {rem_in[SqRemW-3:0], rad[RadW-1-2*k -: 2]};
    assign trial   = SqRemW'({root_in, 2'b01});
    assign ge      = (shifted >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (shifted - trial) : shifted;
        root_q[k] <= {root_in[RootW-2:0], ge};
        len_q[k]  <= len_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign root_o = root_q[SqrtSteps-1];
  assign side_o = side_q[SqrtSteps-1];

endmodule

>>> hw/rtl/icos_div.sv
// ----------------------------------------------------------------------------
// icos_div
// Pipelined rounded division of three magnitudes by the root, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module icos_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [icos_pkg::RootW-1:0] root_i,
  input  icos_pkg::norm_side_t       side_i,
  output icos_pkg::quot_t [2:0]      quot_o,
  output icos_pkg::norm_side_t       side_o
);
  import icos_pkg::*;

  logic [DivRemW-1:0] pre_rem_q [3];
  quot_t              pre_lq_q  [3];
  logic [RootW-1:0]   pre_root_q;
  norm_side_t         pre_side_q;

  logic [DivRemW-1:0] rem_q  [QuotW][3];
  quot_t              lq_q   [QuotW][3];
  logic [RootW-1:0]   root_q [QuotW];
  norm_side_t         side_q [QuotW];

  // numerator with half the divisor added for rounding
  for (genvar c = 0; c < 3; c++) begin : g_prep
    logic [NumW-1:0] num;
    assign num = NumW'({side_i.mag[c], {FracShift{1'b0}}}) + NumW'(root_i >> 1);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pre_rem_q[c] <= DivRemW'(num[NumW-1:QuotW]);
        pre_lq_q[c]  <= num[QuotW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_root_q <= root_i;
      pre_side_q <= side_i;
    end
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    logic [RootW-1:0] root_in;
    norm_side_t       side_in;

    if (k == 0) begin : g_first
      assign root_in = pre_root_q;
      assign side_in = pre_side_q;
    end else begin : g_next
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    for (genvar c = 0; c < 3; c++) begin : g_comp
      logic [DivRemW-1:0] rem_in;
      logic [DivRemW-1:0] shifted;
      quot_t              lq_in;
      logic               ge;

      if (k == 0) begin : g_first
        assign rem_in = pre_rem_q[c];
        assign lq_in  = pre_lq_q[c];
      end else begin : g_next
        assign rem_in = rem_q[k-1][c];
        assign lq_in  = lq_q[k-1][c];
      end

      assign shifted = {rem_in[DivRemW-2:0], lq_in[QuotW-1]};
      assign ge      = (shifted >= DivRemW'(root_in));

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][c] <= ge ? (shifted - DivRemW'(root_in)) : shifted;
          lq_q[k][c]  <= {lq_in[QuotW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= root_in;
        side_q[k] <= side_in;
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_out
    assign quot_o[c] = lq_q[QuotW-1][c];
  end
  assign side_o = side_q[QuotW-1];

endmodule

>>> hw/rtl/icos_norm.sv
// ----------------------------------------------------------------------------
// icos_norm
// One midpoint lane: edge sum, squared length, root, division and sign.
// ----------------------------------------------------------------------------
module icos_norm (
  input  logic           clk_i,
  input  logic           en_i,
  input  icos_pkg::vec_t u_i,
  input  icos_pkg::vec_t v_i,
  output icos_pkg::vec_t mid_o
);
  import icos_pkg::*;

  coord_t              uc [3];
  coord_t              vc [3];
  mag_t                mag_q [3];
  logic [2:0]          neg_q;
  logic [LenW-1:0]     len_q;
  norm_side_t          side_q;
  logic [RootW-1:0]    root;
  norm_side_t          root_side;
  quot_t [2:0]         quot;
  norm_side_t          quot_side;
  coord_t              res_d [3];
  vec_t                mid_q;
  logic [LenW-1:0]     sq [3];

  assign uc[0] = u_i.x;
  assign uc[1] = u_i.y;
  assign uc[2] = u_i.z;
  assign vc[0] = v_i.x;
  assign vc[1] = v_i.y;
  assign vc[2] = v_i.z;

  for (genvar c = 0; c < 3; c++) begin : g_sum
    logic signed [MagW-1:0] s;
    assign s  = MagW'(uc[c]) + MagW'(vc[c]);
    assign sq[c] = mag_q[c] * mag_q[c];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[c] <= s[MagW-1];
        mag_q[c] <= s[MagW-1] ? (~s + 1'b1) : s;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q       <= sq[0] + sq[1] + sq[2];
      side_q.mag  <= {mag_q[2], mag_q[1], mag_q[0]};
      side_q.neg  <= neg_q;
      side_q.zero <= (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
    end
  end

  icos_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .len_i  (len_q),
    .side_i (side_q),
    .root_o (root),
    .side_o (root_side)
  );

  icos_div u_div (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .root_i (root),
    .side_i (root_side),
    .quot_o (quot),
    .side_o (quot_side)
  );

  // clamp, sign and zero vector
  for (genvar c = 0; c < 3; c++) begin : g_fin
    quot_t           qc;
    logic [MagW-1:0] negv;
    assign qc   = (quot[c] > 16'd32768) ? 16'd32768 : quot[c];
    assign negv = '0 - {1'b0, qc};
    assign res_d[c] = quot_side.zero   ? '0 :
                      quot_side.neg[c] ? negv[CoordW-1:0] :
                      (qc > 16'd32767) ? 16'sh7fff : coord_t'(qc);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q.x <= res_d[0];
      mid_q.y <= res_d[1];
      mid_q.z <= res_d[2];
    end
  end

  assign mid_o = mid_q;

endmodule

>>> hw/rtl/icos_emit.sv
// ----------------------------------------------------------------------------
// icos_emit
// Output stage: holds one subdivided triangle and sends its four pieces.
// ----------------------------------------------------------------------------
module icos_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  icos_pkg::tri_t tri_i,
  input  icos_pkg::vec_t mab_i,
  input  icos_pkg::vec_t mbc_i,
  input  icos_pkg::vec_t mca_i,
  output logic           take_o,
  icos_out_if.source     out_o
);
  import icos_pkg::*;

  logic   valid_q;
  piece_e piece_q;
  piece_e piece_d;
  tri_t   tri_q;
  vec_t   mab_q;
  vec_t   mbc_q;
  vec_t   mca_q;
  vec_t   p;
  vec_t   q;
  vec_t   r;
  logic   xfer;

  assign xfer   = valid_q && out_o.ready;
  assign take_o = !valid_q || (xfer && (piece_q == PieceCenter));

  always_comb begin
    piece_d = piece_q;
    if (take_o) begin
      piece_d = PieceEdgeB;
    end else if (xfer) begin
      case (piece_q)
        PieceEdgeB:   piece_d = PieceCornerA;
        PieceCornerA: piece_d = PieceCornerC;
        PieceCornerC: piece_d = PieceCenter;
        default:      piece_d = PieceEdgeB;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      piece_q <= PieceEdgeB;
    end else begin
      piece_q <= piece_d;
      if (take_o) begin
        valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      tri_q <= tri_i;
      mab_q <= mab_i;
      mbc_q <= mbc_i;
      mca_q <= mca_i;
    end
  end

  always_comb begin
    case (piece_q)
      PieceEdgeB: begin
        p = mab_q;   q = tri_q.b; r = mbc_q;
      end
      PieceCornerA: begin
        p = tri_q.a; q = mab_q;   r = mca_q;
      end
      PieceCornerC: begin
        p = tri_q.c; q = mca_q;   r = mbc_q;
      end
      default: begin
        p = mbc_q;   q = mca_q;   r = mab_q;
      end
    endcase
  end

  assign out_o.valid      = valid_q;
  assign out_o.p_x        = p.x;
  assign out_o.p_y        = p.y;
  assign out_o.p_z        = p.z;
  assign out_o.q_x        = q.x;
  assign out_o.q_y        = q.y;
  assign out_o.q_z        = q.z;
  assign out_o.r_x        = r.x;
  assign out_o.r_y        = r.y;
  assign out_o.r_z        = r.z;
  assign out_o.piece      = piece_q;
  assign out_o.last_piece = (piece_q == PieceCenter);

endmodule

>>> hw/rtl/icosphere_triangle_subdivider.sv
// ----------------------------------------------------------------------------
// icosphere_triangle_subdivider
// One level of icosphere subdivision: three normalized edge midpoints and
// four sub-triangles per input triangle.
//
//   channel  dir  payload                          transfer when
//   in_i     in   a, b, c vertices, Q2.14          valid && ready
//   out_o    out  p, q, r corners, piece, last     valid && ready
//
// An input triangle passes 51 pipeline stages (sum, square, 31 root
// stages, 16 divide stages and framing) and the output register before
// its first piece. The output stage sends four pieces per triangle and
// takes the next only after its last piece is sent. Reset clears only the
// valid bits and the piece state. When the output stalls the whole
// pipeline holds; bubbles move forward while the last stage is empty.
// ----------------------------------------------------------------------------
module icosphere_triangle_subdivider (
  input  logic       clk_i,
  input  logic       rst_ni,
  icos_in_if.sink    in_i,
  icos_out_if.source out_o
);
  import icos_pkg::*;

  logic [NormLat-1:0] valid_q;
  tri_t               tri_q [NormLat];
  tri_t               tri_in;
  vec_t               mab;
  vec_t               mbc;
  vec_t               mca;
  logic               take;
  logic               en;

  assign en = take || !valid_q[NormLat-1];
  assign in_i.ready = en;

  assign tri_in.a.x = in_i.a_x;
  assign tri_in.a.y = in_i.a_y;
  assign tri_in.a.z = in_i.a_z;
  assign tri_in.b.x = in_i.b_x;
  assign tri_in.b.y = in_i.b_y;
  assign tri_in.b.z = in_i.b_z;
  assign tri_in.c.x = in_i.c_x;
  assign tri_in.c.y = in_i.c_y;
  assign tri_in.c.z = in_i.c_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NormLat-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tri_q[0] <= tri_in;
      for (int k = 1; k < NormLat; k++) begin
        tri_q[k] <= tri_q[k-1];
      end
    end
  end

  icos_norm u_norm_ab (
    .clk_i (clk_i),
    .en_i  (en),
    .u_i   (tri_in.a),
    .v_i   (tri_in.b),
    .mid_o (mab)
  );

  icos_norm u_norm_bc (
    .clk_i (clk_i),
    .en_i  (en),
    .u_i   (tri_in.b),
    .v_i   (tri_in.c),
    .mid_o (mbc)
  );

  icos_norm u_norm_ca (
    .clk_i (clk_i),
    .en_i  (en),
    .u_i   (tri_in.c),
    .v_i   (tri_in.a),
    .mid_o (mca)
  );

  icos_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_q[NormLat-1]),
    .tri_i   (tri_q[NormLat-1]),
    .mab_i   (mab),
    .mbc_i   (mbc),
    .mca_i   (mca),
    .take_o  (take),
    .out_o   (out_o)
  );

endmodule
